@@ hdl/ln_pkg.sv @@
// Shared types and constants for the layer normalisation engine.
`default_nettype none

package ln_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int MAX_ROW_DEF = 64;
    localparam int LEN_W       = 7;
    localparam int INDEX_W     = 6;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 1'd1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    localparam logic [LEN_W-1:0]      ROW_LENGTH_RST = 7'd64;
    localparam logic [CFG_DATA_W-1:0] EPSILON_RST    = 16'd1;
    localparam logic [DATA_WIDTH-1:0] GAMMA_ONE      = 16'd256;

    localparam int NEWTON_STEPS = 5;
    localparam logic [31:0] TWO_Q30    = 32'h8000_0000;
    localparam logic [31:0] THREE_Q30  = 32'hC000_0000;
    localparam logic [31:0] SEED_SMALL = 32'd912680550;
    localparam logic [31:0] SEED_LARGE = 32'd644245094;

    typedef struct packed {
        logic                         mode;
        logic [INDEX_W-1:0]           index;
        logic signed [DATA_WIDTH-1:0] gamma;
        logic signed [DATA_WIDTH-1:0] beta;
        logic signed [DATA_WIDTH-1:0] sample;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] normalized;
        logic                         last;
        logic                         clipped;
    } t_out_word;

endpackage

`default_nettype wire

@@ hdl/ln_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ln_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  logic                          i_we,
    input  logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  logic [WIDTH-1:0]              i_wdata,
    input  logic [$clog2(DEPTH)-1:0]      i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/layer_norm_engine.sv @@
// Layer normalisation engine: row buffer, statistics, inverse square root, affine output.
//
// Input channel (i_in_valid / o_in_stall, word i_in_word): a load word (mode 0) writes
// one gamma/beta pair; a data word (mode 1) is buffered. Both are accepted while idle until the
// word that completes a row. That word starts the row computation and the input stalls:
//   mean divide        one quotient bit a cycle, shared divider
//   variance pass      per sample: row RAM read, difference, square, add
//   variance divide    on the same shared divider
//   exponent search    one bit a cycle
//   Newton iteration   5 steps of 3 multiplies
//   output pass        per sample: read, difference, multiply, round, gamma, beta; held while output stalls
// Results (o_out_valid / i_out_stall, word o_out_word) come out in position order with
// last set on the final one. The output register holds a stalled word unchanged; input
// is taken again as soon as the final word of a row sits in the output register.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready; writing row_length drops
// a partial row. After reset the gamma/beta RAM is swept to one/zero, entry by entry,
// during which the input stalls.
`default_nettype none

module layer_norm_engine #(
    parameter int MAX_ROW = ln_pkg::MAX_ROW_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  ln_pkg::t_in_word                   i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output ln_pkg::t_out_word                  o_out_word,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ln_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ln_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int DW    = ln_pkg::DATA_WIDTH;
    localparam int NMAX  = (MAX_ROW < 127) ? MAX_ROW : 127;
    localparam int CNTW  = $clog2(NMAX + 1);
    localparam int RW    = $clog2(NMAX);
    localparam int AW    = $clog2(MAX_ROW);
    localparam int SUM_W = DW + CNTW;
    localparam int D_W   = DW + 9;
    localparam int SQ_B  = 2 * (D_W - 1);
    localparam int SQ_W  = SQ_B + CNTW;
    localparam int DIV_W = SQ_W;
    localparam int DCW   = $clog2(DIV_W);
    localparam int V_W   = SQ_B + 1;
    localparam int PW    = $clog2(V_W);
    localparam int P_W   = D_W + 33;
    localparam int XH_W  = 28;
    localparam int GP_W  = XH_W + DW;
    localparam int R_W   = GP_W - 14;
    localparam logic signed [R_W-1:0] RES_HI = R_W'((2 ** (DW - 1)) - 1);
    localparam logic signed [R_W-1:0] RES_LO = -RES_HI - R_W'(1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MDIV  = 3'd2;
    localparam logic [2:0] S_VAR   = 3'd3;
    localparam logic [2:0] S_VDIV  = 3'd4;
    localparam logic [2:0] S_NORM  = 3'd5;
    localparam logic [2:0] S_NEWT  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]                r_state, n_state;
    logic [AW-1:0]             r_clr, n_clr;
    logic [ln_pkg::LEN_W-1:0]  r_len, n_len;
    logic [15:0]               r_eps, n_eps;
    logic [CNTW-1:0]           r_fill, n_fill;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic [2:0]                r_ph, n_ph;
    logic [CNTW-1:0]           r_i, n_i;
    logic [2:0]                r_step, n_step;
    logic                      r_out_valid, n_out_valid;
    logic [DCW-1:0]            r_dcnt, n_dcnt;
    logic [PW-1:0]             r_p, n_p;

    logic [CNTW-1:0]           r_n, n_n;
    logic [DIV_W-1:0]          r_dnum, n_dnum;
    logic [CNTW-1:0]           r_drem, n_drem;
    logic                      r_dneg, n_dneg;
    logic signed [D_W-1:0]     r_mean, n_mean;
    logic signed [D_W-1:0]     r_d, n_d;
    logic [SQ_B-1:0]           r_sq, n_sq;
    logic [SQ_W-1:0]           r_acc, n_acc;
    logic [V_W-1:0]            r_v, n_v;
    logic [V_W-1:0]            r_vs, n_vs;
    logic [31:0]               r_m, n_m;
    logic [31:0]               r_y, n_y;
    logic [33:0]               r_y2, n_y2;
    logic [31:0]               r_t, n_t;
    logic [5:0]                r_sh, n_sh;
    logic                      r_zero, n_zero;
    logic signed [P_W-1:0]     r_prod, n_prod;
    logic signed [XH_W-1:0]    r_xh, n_xh;
    logic signed [GP_W-1:0]    r_gp, n_gp;
    ln_pkg::t_out_word         r_out, n_out;

    logic                      row_we;
    logic [RW-1:0]             row_waddr;
    logic [DW-1:0]             row_q;
    logic                      aff_we;
    logic [AW-1:0]             aff_waddr;
    logic [2*DW-1:0]           aff_wdata;
    logic [2*DW-1:0]           aff_q;

    logic                      in_acc;
    logic                      out_take;

    ln_ram #(.WIDTH(DW), .DEPTH(NMAX)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (i_in_word.sample),
        .i_raddr (r_i[RW-1:0]),
        .o_rdata (row_q)
    );

    ln_ram #(.WIDTH(2 * DW), .DEPTH(MAX_ROW)) u_aff_ram (
        .i_clk   (i_clk),
        .i_we    (aff_we),
        .i_waddr (aff_waddr),
        .i_wdata (aff_wdata),
        .i_raddr (AW'(r_i)),
        .o_rdata (aff_q)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        logic [CNTW-1:0]         len_c;
        logic [CNTW-1:0]         idx;
        logic signed [SUM_W-1:0] sum_new;
        logic [SUM_W-1:0]        sum_mag;
        logic [CNTW:0]           rem_sh;
        logic                    ge;
        logic [DIV_W-1:0]        q_step;
        logic [CNTW-1:0]         rem_step;
        logic [SQ_W-1:0]         acc_new;
        logic signed [2*D_W-1:0] sq_full;
        logic signed [6:0]       tk;
        logic [63:0]             vwide;
        logic [63:0]             yy;
        logic [65:0]             my;
        logic [35:0]             tt;
        logic [63:0]             yn;
        logic signed [P_W-1:0]   prod_c;
        logic [P_W-1:0]          pmag;
        logic [P_W-1:0]          prnd;
        logic [XH_W-1:0]         xmag;
        logic signed [GP_W-1:0]  gp_c;
        logic [GP_W-1:0]         gmag;
        logic [GP_W-1:0]         gr;
        logic signed [R_W-1:0]   rq;
        logic signed [R_W-1:0]   res;

        n_state = r_state;  n_clr = r_clr;   n_len = r_len;    n_eps = r_eps;
        n_fill = r_fill;    n_sum = r_sum;   n_ph = r_ph;      n_i = r_i;
        n_step = r_step;    n_dcnt = r_dcnt; n_p = r_p;        n_n = r_n;
        n_dnum = r_dnum;    n_drem = r_drem; n_dneg = r_dneg;  n_mean = r_mean;
        n_d = r_d;          n_sq = r_sq;     n_acc = r_acc;    n_v = r_v;
        n_vs = r_vs;        n_m = r_m;       n_y = r_y;        n_y2 = r_y2;
        n_t = r_t;          n_sh = r_sh;     n_zero = r_zero;  n_prod = r_prod;
        n_xh = r_xh;        n_gp = r_gp;     n_out = r_out;
        n_out_valid = out_take ? 1'b0 : r_out_valid;

        row_we    = 1'b0;
        aff_we    = 1'b0;
        aff_waddr = AW'(i_in_word.index);
        aff_wdata = {i_in_word.gamma, i_in_word.beta};

        if (r_len == '0) begin
            len_c = CNTW'(1);
        end else if ({1'b0, r_len} > 8'(NMAX)) begin
            len_c = CNTW'(NMAX);
        end else begin
            len_c = CNTW'(r_len);
        end
        idx       = (r_fill >= len_c) ? '0 : r_fill;
        row_waddr = idx[RW-1:0];
        sum_new   = ((r_fill >= len_c) ? '0 : r_sum) + SUM_W'(i_in_word.sample);
        sum_mag   = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

        rem_sh   = {r_drem, r_dnum[DIV_W-1]};
        ge       = (rem_sh >= {1'b0, r_n});
        rem_step = ge ? CNTW'(rem_sh - {1'b0, r_n}) : rem_sh[CNTW-1:0];
        q_step   = {r_dnum[DIV_W-2:0], ge};

        sq_full = r_d * r_d;
        acc_new = r_acc + SQ_W'(r_sq);

        tk    = $signed({1'b0, r_p}) - (r_p[0] ? 7'sd31 : 7'sd30);
        vwide = (tk >= 0) ? (64'(r_v) >> tk) : (64'(r_v) << (-tk));

        yy = 64'(r_y) * 64'(r_y);
        my = 66'(r_m) * 66'(r_y2);
        tt = my[65:30];
        yn = 64'(r_y) * 64'(ln_pkg::THREE_Q30 - r_t);

        prod_c = r_d * $signed({1'b0, r_y});
        pmag   = r_prod[P_W-1] ? P_W'(-r_prod) : P_W'(r_prod);
        prnd   = P_W'(1) << (r_sh - 6'd1);
        xmag   = XH_W'((pmag + prnd) >> r_sh);

        gp_c = $signed(aff_q[2*DW-1:DW]) * r_xh;
        gmag = r_gp[GP_W-1] ? GP_W'(-r_gp) : GP_W'(r_gp);
        gr   = (gmag + GP_W'(2 ** 15)) >> 16;
        rq   = r_gp[GP_W-1] ? -R_W'(gr) : R_W'(gr);
        res  = rq + R_W'($signed(aff_q[DW-1:0]));

        case (r_state)
            S_CLEAR: begin
                aff_we    = 1'b1;
                aff_waddr = r_clr;
                aff_wdata = {ln_pkg::GAMMA_ONE, {DW{1'b0}}};
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(MAX_ROW - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.mode == ln_pkg::MODE_LOAD) begin
                        aff_we = (32'(i_in_word.index) < MAX_ROW);
                    end else begin
                        row_we = 1'b1;
                        n_sum  = sum_new;
                        n_fill = idx + CNTW'(1);
                        if (idx + CNTW'(1) == len_c) begin
                            n_n     = len_c;
                            n_dnum  = DIV_W'({sum_mag, 8'd0});
                            n_drem  = '0;
                            n_dneg  = sum_new[SUM_W-1];
                            n_dcnt  = '0;
                            n_state = S_MDIV;
                        end
                    end
                end
            end
            S_MDIV: begin
                n_dnum = q_step;
                n_drem = rem_step;
                n_dcnt = r_dcnt + DCW'(1);
                if (r_dcnt == DCW'(DIV_W - 1)) begin
                    n_mean  = r_dneg ? -D_W'(q_step) : D_W'(q_step);
                    n_i     = '0;
                    n_ph    = '0;
                    n_acc   = '0;
                    n_state = S_VAR;
                end
            end
            S_VAR: begin
                n_ph = r_ph + 3'd1;
                case (r_ph)
                    3'd0: ;
                    3'd1: n_d = (D_W'($signed(row_q)) <<< 8) - r_mean;
                    3'd2: n_sq = sq_full[SQ_B-1:0];
                    default: begin
                        n_acc = acc_new;
                        n_ph  = '0;
                        if (r_i == r_n - CNTW'(1)) begin
                            n_dnum  = DIV_W'(acc_new);
                            n_drem  = '0;
                            n_dcnt  = '0;
                            n_state = S_VDIV;
                        end else begin
                            n_i = r_i + CNTW'(1);
                        end
                    end
                endcase
            end
            S_VDIV: begin
                n_dnum = q_step;
                n_drem = rem_step;
                n_dcnt = r_dcnt + DCW'(1);
                if (r_dcnt == DCW'(DIV_W - 1)) begin
                    n_v     = V_W'(q_step) + (V_W'(r_eps) << 16);
                    n_vs    = V_W'(q_step) + (V_W'(r_eps) << 16);
                    n_p     = '0;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (r_v == '0) begin
                    n_zero  = 1'b1;
                    n_i     = '0;
                    n_ph    = '0;
                    n_state = S_OUT;
                end else if (r_vs[V_W-1:1] != '0) begin
                    n_vs = r_vs >> 1;
                    n_p  = r_p + PW'(1);
                end else begin
                    n_zero  = 1'b0;
                    n_m     = vwide[31:0];
                    n_y     = (vwide[31:0] < ln_pkg::TWO_Q30) ? ln_pkg::SEED_SMALL
                                                              : ln_pkg::SEED_LARGE;
                    n_sh    = 6'(7'(tk >>> 1) + 7'sd29);
                    n_step  = '0;
                    n_ph    = '0;
                    n_state = S_NEWT;
                end
            end
            S_NEWT: begin
                n_ph = r_ph + 3'd1;
                case (r_ph)
                    3'd0: n_y2 = yy[63:30];
                    3'd1: n_t = (tt >= 36'(ln_pkg::THREE_Q30)) ?
                                (ln_pkg::THREE_Q30 - 32'd1) : tt[31:0];
                    default: begin
                        n_y    = yn[62:31];
                        n_ph   = '0;
                        n_step = r_step + 3'd1;
                        if (r_step == 3'(ln_pkg::NEWTON_STEPS - 1)) begin
                            n_i     = '0;
                            n_state = S_OUT;
                        end
                    end
                endcase
            end
            S_OUT: begin
                n_ph = r_ph + 3'd1;
                case (r_ph)
                    3'd0: ;
                    3'd1: n_d = (D_W'($signed(row_q)) <<< 8) - r_mean;
                    3'd2: n_prod = prod_c;
                    3'd3: n_xh = r_zero ? '0 :
                                 (r_prod[P_W-1] ? -$signed(xmag) : $signed(xmag));
                    3'd4: n_gp = gp_c;
                    default: begin
                        n_ph = r_ph;
                        if (!r_out_valid || !i_out_stall) begin
                            n_out_valid      = 1'b1;
                            n_out.last       = (r_i == r_n - CNTW'(1));
                            n_out.clipped    = (res > RES_HI) || (res < RES_LO);
                            n_out.normalized = (res > RES_HI) ? DW'(RES_HI) :
                                               (res < RES_LO) ? DW'(RES_LO) : DW'(res);
                            n_ph = '0;
                            if (r_i == r_n - CNTW'(1)) begin
                                n_fill  = '0;
                                n_sum   = '0;
                                n_state = S_IDLE;
                            end else begin
                                n_i = r_i + CNTW'(1);
                            end
                        end
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_valid) begin
            if (i_cfg_index == ln_pkg::CFG_ROW_LENGTH) begin
                n_len  = i_cfg_data[ln_pkg::LEN_W-1:0];
                n_fill = '0;
                n_sum  = '0;
            end else if (i_cfg_index == ln_pkg::CFG_EPSILON) begin
                n_eps = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_len       <= ln_pkg::ROW_LENGTH_RST;
            r_eps       <= ln_pkg::EPSILON_RST;
            r_fill      <= '0;
            r_sum       <= '0;
            r_ph        <= '0;
            r_i         <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
            r_p         <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_len       <= n_len;
            r_eps       <= n_eps;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_ph        <= n_ph;
            r_i         <= n_i;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_dcnt      <= n_dcnt;
            r_p         <= n_p;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_dnum <= n_dnum;
        r_drem <= n_drem;
        r_dneg <= n_dneg;
        r_mean <= n_mean;
        r_d    <= n_d;
        r_sq   <= n_sq;
        r_acc  <= n_acc;
        r_v    <= n_v;
        r_vs   <= n_vs;
        r_m    <= n_m;
        r_y    <= n_y;
        r_y2   <= n_y2;
        r_t    <= n_t;
        r_sh   <= n_sh;
        r_zero <= n_zero;
        r_prod <= n_prod;
        r_xh   <= n_xh;
        r_gp   <= n_gp;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire
